>>> design/srm_pkg.sv
// Shared constants, request codes and address helpers for the sparse row
// multiply-accumulate engine. No dependencies.
`timescale 1ns / 1ps

package srm_pkg;

    localparam int ROW_COUNT   = 256;
    localparam int ROW_WIDTH   = 64;
    localparam int STORE_DEPTH = ROW_COUNT * ROW_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_CNT_W   = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;

    localparam logic [1:0] REQ_WRITE_RIGHT = 2'd0;
    localparam logic [1:0] REQ_WRITE_OUT   = 2'd1;
    localparam logic [1:0] REQ_ENTRY       = 2'd2;
    localparam logic [1:0] REQ_READ_OUT    = 2'd3;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [30:0] POS_INF   = 31'h7F80_0000;

    function automatic logic row_ok(input logic [7:0] row);
        row_ok = int'(row) < ROW_COUNT;
    endfunction

    function automatic logic col_ok(input logic [7:0] col);
        col_ok = int'(col) < ROW_WIDTH;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [7:0] row,
                                                   input logic [7:0] col);
        addr_of = ADDR_W'(int'(row) * ROW_WIDTH + int'(col));
    endfunction

endpackage

>>> design/srm_fma.sv
// Multi-cycle binary32 fused multiply-add, round to nearest even.
// Uses srm_pkg for the canonical NaN and infinity patterns.
`timescale 1ns / 1ps

module srm_fma (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic        o_done,
    output logic [31:0] o_result
);
    import srm_pkg::*;

    typedef logic signed [10:0] t_exp;
    typedef struct packed {
        logic [63:0] m;
        t_exp        e;
    } t_norm;

    typedef enum logic [7:0] {
        F_IDLE  = 8'b0000_0001,
        F_MUL   = 8'b0000_0010,
        F_NORM  = 8'b0000_0100,
        F_ALIGN = 8'b0000_1000,
        F_ADD   = 8'b0001_0000,
        F_RNORM = 8'b0010_0000,
        F_SHIFT = 8'b0100_0000,
        F_ROUND = 8'b1000_0000
    } t_fstate;

    // One normalizing step toward bit 61: by eight when bits 61 to 54 are all clear, else by one.
    function automatic t_norm norm_step(input logic [63:0] m, input t_exp e);
        t_norm r;
        r.m = m;
        r.e = e;
        if (m != 64'd0 && !m[61]) begin
            if (m[61:54] == 8'd0) begin
                r.m = m << 8;
                r.e = e - 11'sd8;
            end else begin
                r.m = m << 1;
                r.e = e - 11'sd1;
            end
        end
        return r;
    endfunction

    t_fstate     r_state, n_state;
    logic [31:0] r_a, r_b, r_c, r_res;
    logic        r_done;
    logic [63:0] r_pm, r_cm, r_big, r_small, r_m;
    t_exp        r_pe, r_ce, r_e;
    logic        r_ps, r_sc, r_czero, r_bsign, r_same;
    logic [23:0] r_q;
    logic        r_rnd, r_stk;
    logic [9:0]  r_be;

    // Operand decode.
    logic [7:0]  ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic        azero, bzero, czero, any_nan, ps;
    logic [23:0] ma, mb, mc;
    t_exp        pe, ce;
    logic [47:0] prod;

    always_comb begin
        ea = r_a[30:23];
        eb = r_b[30:23];
        ec = r_c[30:23];
        fa = r_a[22:0];
        fb = r_b[22:0];
        fc = r_c[22:0];
        azero = (ea == 8'd0) && (fa == 23'd0);
        bzero = (eb == 8'd0) && (fb == 23'd0);
        czero = (ec == 8'd0) && (fc == 23'd0);
        any_nan = (ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0) ||
                  (ec == 8'hFF && fc != 23'd0);
        ps = r_a[31] ^ r_b[31];
        ma = {ea != 8'd0, fa};
        mb = {eb != 8'd0, fb};
        mc = {ec != 8'd0, fc};
        pe = $signed({3'b000, (ea == 8'd0) ? 8'd1 : ea}) +
             $signed({3'b000, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd314;
        ce = $signed({3'b000, (ec == 8'd0) ? 8'd1 : ec}) - 11'sd188;
        prod = ma * mb;
    end

    t_norm p_step, c_step, m_step;
    logic  norm_done;

    always_comb begin
        p_step = norm_step(r_pm, r_pe);
        c_step = norm_step(r_cm, r_ce);
        m_step = norm_step(r_m, r_e);
        norm_done = r_pm[61] && (r_cm[61] || r_cm == 64'd0);
    end

    // Compare, swap and align with sticky.
    logic        p_big;
    t_exp        d;
    logic [63:0] small_in, small_al;
    logic [5:0]  d6;

    always_comb begin
        p_big = r_czero || (r_pe > r_ce) || (r_pe == r_ce && r_pm >= r_cm);
        d = p_big ? (r_pe - r_ce) : (r_ce - r_pe);
        small_in = r_czero ? 64'd0 : (p_big ? r_cm : r_pm);
        d6 = d[5:0];
        if (d >= 11'sd63) begin
            small_al = {63'd0, small_in != 64'd0};
        end else begin
            small_al = (small_in >> d6) |
                       {63'd0, |(small_in & ~({64{1'b1}} << d6))};
        end
    end

    // Rounding shift; subnormal results shift further.
    t_exp        biased, shv;
    logic        is_sub;
    logic [5:0]  sh6, rpos;
    logic [63:0] shifted;

    always_comb begin
        biased = r_e + 11'sd188;
        is_sub = biased < 11'sd1;
        shv = is_sub ? (-11'sd149 - r_e) : 11'sd38;
        sh6 = (shv > 11'sd63) ? 6'd63 : shv[5:0];
        rpos = sh6 - 6'd1;
        shifted = r_m >> sh6;
    end

    logic        inc;
    logic [24:0] qr;
    logic [33:0] bits;

    always_comb begin
        inc = r_rnd & (r_stk | r_q[0]);
        qr = {1'b0, r_q} + {24'd0, inc};
        bits = ((34'(r_be) - 34'd1) << 23) + 34'(qr);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_start) n_state = F_MUL;
            F_MUL: begin
                if (any_nan || ea == 8'hFF || eb == 8'hFF || ec == 8'hFF ||
                    azero || bzero) begin
                    n_state = F_IDLE;
                end else begin
                    n_state = F_NORM;
                end
            end
            F_NORM:  if (norm_done) n_state = F_ALIGN;
            F_ALIGN: n_state = F_ADD;
            F_ADD: begin
                if (r_same) n_state = F_RNORM;
                else if (r_big == r_small) n_state = F_IDLE;
                else n_state = F_RNORM;
            end
            F_RNORM: if (!r_m[62] && r_m[61]) n_state = F_SHIFT;
            F_SHIFT: n_state = F_ROUND;
            F_ROUND: n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            case (r_state)
                F_MUL: begin
                    if (n_state == F_IDLE) r_done <= 1'b1;
                end
                F_ADD: begin
                    if (n_state == F_IDLE) r_done <= 1'b1;
                end
                F_ROUND: r_done <= 1'b1;
                default: r_done <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_a <= i_a;
                r_b <= i_b;
                r_c <= i_c;
            end
            F_MUL: begin
                r_pm    <= {2'b00, prod, 14'd0};
                r_pe    <= pe;
                r_cm    <= {2'b00, mc, 38'd0};
                r_ce    <= ce;
                r_ps    <= ps;
                r_sc    <= r_c[31];
                r_czero <= czero;
                if (any_nan) begin
                    r_res <= CANON_NAN;
                end else if (ea == 8'hFF || eb == 8'hFF) begin
                    if (azero || bzero) r_res <= CANON_NAN;
                    else if (ec == 8'hFF && r_c[31] != ps) r_res <= CANON_NAN;
                    else r_res <= {ps, POS_INF};
                end else if (ec == 8'hFF) begin
                    r_res <= r_c;
                end else if (azero || bzero) begin
                    r_res <= czero ? {ps & r_c[31], 31'd0} : r_c;
                end
            end
            F_NORM: begin
                r_pm <= p_step.m;
                r_pe <= p_step.e;
                r_cm <= c_step.m;
                r_ce <= c_step.e;
            end
            F_ALIGN: begin
                r_big   <= p_big ? r_pm : r_cm;
                r_small <= small_al;
                r_e     <= p_big ? r_pe : r_ce;
                r_bsign <= p_big ? r_ps : r_sc;
                r_same  <= r_czero || (r_ps == r_sc);
            end
            F_ADD: begin
                r_m <= r_same ? (r_big + r_small) : (r_big - r_small);
                // An exactly cancelling sum is positive zero.
                r_res <= 32'd0;
            end
            F_RNORM: begin
                if (r_m[62]) begin
                    r_m <= {1'b0, r_m[63:1]} | {63'd0, r_m[0]};
                    r_e <= r_e + 11'sd1;
                end else begin
                    r_m <= m_step.m;
                    r_e <= m_step.e;
                end
            end
            F_SHIFT: begin
                r_q   <= shifted[23:0];
                r_rnd <= r_m[rpos];
                r_stk <= |(r_m & ~({64{1'b1}} << rpos));
                r_be  <= is_sub ? 10'd1 : biased[9:0];
            end
            F_ROUND: begin
                r_res <= {r_bsign, (bits >= 34'(POS_INF)) ? POS_INF : bits[30:0]};
            end
            default: r_res <= r_res;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> design/sparse_row_mac_engine.sv
// Top level of the sparse row multiply-accumulate engine: request decode,
// the two row stores and the column sequencer. Uses srm_pkg and srm_fma.
`timescale 1ns / 1ps

// A request transfers when start is high and busy is low. Element writes
// finish in the transfer cycle and busy stays low. A read raises busy
// through ST_READ1 and ST_READ2; the element appears with o_read_valid for
// one cycle, in ST_READ2. There is no back-pressure on results; the
// receiver must take the strobe when it comes.
// A sparse entry with all rows in range walks every column of the output
// row. Each column takes a store read in ST_RD and three passes through the
// shared fused multiply-add unit; a pass takes longer when subnormal
// operands need longer normalization. Entries out of range are dropped at
// once. Reset returns the sequencer to idle; store contents are not
// cleared, and an element reads as whatever was last written there.

module sparse_row_mac_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_out_row,
    input  logic [7:0]  i_right_row_a,
    input  logic [7:0]  i_right_row_b,
    input  logic [7:0]  i_right_row_c,
    input  logic [5:0]  i_column,
    input  logic [31:0] i_value,
    input  logic [31:0] i_weight_a,
    input  logic [31:0] i_weight_b,
    input  logic [31:0] i_weight_c,
    output logic        o_read_valid,
    output logic [31:0] o_read_data,
    output logic [7:0]  o_read_row,
    output logic [5:0]  o_read_column
);
    import srm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_RD    = 7'b000_0010,
        ST_RUN_A = 7'b000_0100,
        ST_RUN_B = 7'b000_1000,
        ST_RUN_C = 7'b001_0000,
        ST_READ1 = 7'b010_0000,
        ST_READ2 = 7'b100_0000
    } t_state;

    t_state               r_state, n_state;
    logic [7:0]           r_orow, r_ra, r_rb, r_rc;
    logic [5:0]           r_rcol;
    logic [31:0]          r_wa, r_wb, r_wc;
    logic [COL_CNT_W-1:0] r_x;
    logic                 r_kick;

    logic [31:0] r_right_mem [STORE_DEPTH];
    logic [31:0] r_out_mem   [STORE_DEPTH];
    logic [31:0] r_rq, r_oq;

    logic              accept, entry_ok, last_col;
    logic [7:0]        cur_right_row, col8;
    logic [ADDR_W-1:0] right_raddr, out_raddr, out_waddr;
    logic              right_we, out_we;
    logic [31:0]       out_wdata;
    logic [31:0]       fma_a, fma_c, fma_res;
    logic              fma_done;

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign entry_ok = row_ok(i_out_row) && row_ok(i_right_row_a) &&
                      row_ok(i_right_row_b) && row_ok(i_right_row_c);
    assign last_col = (r_x == COL_CNT_W'(ROW_WIDTH - 1));
    assign col8     = 8'(r_x);

    // The right row read runs one step ahead of the multiply-add unit.
    always_comb begin
        case (r_state)
            ST_RUN_A: cur_right_row = r_rb;
            ST_RUN_B: cur_right_row = r_rc;
            default:  cur_right_row = r_ra;
        endcase
        right_raddr = addr_of(cur_right_row, col8);
        out_raddr   = (r_state == ST_READ1) ? addr_of(r_orow, {2'b00, r_rcol})
                                            : addr_of(r_orow, col8);
        right_we = accept && i_req_type == REQ_WRITE_RIGHT &&
                   row_ok(i_right_row_a) && col_ok({2'b00, i_column});
        if (r_state == ST_RUN_C && fma_done) begin
            out_we    = 1'b1;
            out_waddr = addr_of(r_orow, col8);
            out_wdata = fma_res;
        end else begin
            out_we    = accept && i_req_type == REQ_WRITE_OUT &&
                        row_ok(i_out_row) && col_ok({2'b00, i_column});
            out_waddr = addr_of(i_out_row, {2'b00, i_column});
            out_wdata = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (right_we) begin
            r_right_mem[addr_of(i_right_row_a, {2'b00, i_column})] <= i_value;
        end
        r_rq <= r_right_mem[right_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (out_we) begin
            r_out_mem[out_waddr] <= out_wdata;
        end
        r_oq <= r_out_mem[out_raddr];
    end

    always_comb begin
        case (r_state)
            ST_RUN_B: fma_a = r_wb;
            ST_RUN_C: fma_a = r_wc;
            default:  fma_a = r_wa;
        endcase
        fma_c = (r_state == ST_RUN_A) ? r_oq : fma_res;
    end

    srm_fma u_fma (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_kick),
        .i_a      (fma_a),
        .i_b      (r_rq),
        .i_c      (fma_c),
        .o_done   (fma_done),
        .o_result (fma_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_req_type == REQ_ENTRY && entry_ok) n_state = ST_RD;
                else if (accept && i_req_type == REQ_READ_OUT) n_state = ST_READ1;
            end
            ST_RD:    n_state = ST_RUN_A;
            ST_RUN_A: if (fma_done) n_state = ST_RUN_B;
            ST_RUN_B: if (fma_done) n_state = ST_RUN_C;
            ST_RUN_C: if (fma_done) n_state = last_col ? ST_IDLE : ST_RD;
            ST_READ1: n_state = ST_READ2;
            ST_READ2: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kick  <= 1'b0;
            r_x     <= '0;
        end else begin
            r_state <= n_state;
            r_kick  <= (r_state == ST_RD) ||
                       (fma_done && (r_state == ST_RUN_A || r_state == ST_RUN_B));
            if (r_state == ST_IDLE) begin
                r_x <= '0;
            end else if (r_state == ST_RUN_C && fma_done) begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_orow <= i_out_row;
            r_ra   <= i_right_row_a;
            r_rb   <= i_right_row_b;
            r_rc   <= i_right_row_c;
            r_rcol <= i_column;
            r_wa   <= i_weight_a;
            r_wb   <= i_weight_b;
            r_wc   <= i_weight_c;
        end
    end

    assign o_read_valid  = (r_state == ST_READ2);
    assign o_read_data   = (row_ok(r_orow) && col_ok({2'b00, r_rcol})) ? r_oq : 32'd0;
    assign o_read_row    = r_orow;
    assign o_read_column = r_rcol;

endmodule

>>> design/srm_checker.sv
// Port-level checks for the sparse row multiply-accumulate engine and the
// bind that attaches them. Uses srm_pkg for the request codes.
`timescale 1ns / 1ps

module srm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_req_type,
    input logic [7:0]  i_out_row,
    input logic [5:0]  i_column,
    input logic        o_read_valid,
    input logic [7:0]  o_read_row,
    input logic [5:0]  o_read_column
);
    import srm_pkg::*;

    logic rd_xfer, wr_xfer;
    assign rd_xfer = start && !busy && i_req_type == REQ_READ_OUT;
    assign wr_xfer = start && !busy &&
                     (i_req_type == REQ_WRITE_RIGHT || i_req_type == REQ_WRITE_OUT);

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_read_valid |-> busy)
        else $error("read strobe while not busy");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_xfer |=> busy ##1 o_read_valid)
        else $error("read result not returned two cycles after transfer");

    a_read_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_xfer |=> ##1 (o_read_row == $past(i_out_row, 2) &&
                         o_read_column == $past(i_column, 2)))
        else $error("read result does not echo the requested element");

    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_xfer |=> !busy && !o_read_valid)
        else $error("element write kept the block busy");

    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_read_valid |=> !busy && !o_read_valid)
        else $error("read strobe longer than one cycle");

endmodule

bind sparse_row_mac_engine srm_checker u_srm_checker (.*);
